FILE: hw/rtl/sh64m_pkg.sv
// ----------------------------------------------------------------------------
// sh64m_pkg
// Shared types and constants of the streaming 64-bit multiply-rotate hash.
// ----------------------------------------------------------------------------
package sh64m_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] FMIX1  = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FMIX2  = 64'hC4CE_B9FE_1A85_EC53;
    localparam int unsigned ROT_AMOUNT = 31;
    localparam int unsigned AVAL_SHIFT = 33;

    localparam int unsigned S_TDATA_W = 72;  // 64 data bits + 4 count bits, byte padded
    localparam int unsigned M_TDATA_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_MUL1,
        ST_W_ROT,
        ST_W_MUL2,
        ST_W_DONE,
        ST_F_CHK,
        ST_F_LOAD,
        ST_F_MUL1,
        ST_F_AV,
        ST_F_MUL2,
        ST_F_OUT
    } state_t;

    // Source of the multiplicand register.
    typedef enum logic [2:0] {
        A_COMB,   // freshly completed word from the input transfer
        A_PART,   // zero-padded partial word
        A_ROT,    // rotl(hash ^ product, 31)
        A_FIN,    // (hash ^ total) ^ ((hash ^ total) >> 33)
        A_AVAL    // product ^ (product >> 33)
    } a_sel_t;

    typedef enum logic [1:0] {
        K_P1,
        K_P2,
        K_F1,
        K_F2
    } k_sel_t;

    // Partial-product step of a 64x64 multiply, low 64 bits kept.
    typedef enum logic [1:0] {
        PH_LL,    // a_lo * b_lo
        PH_LH,    // + (a_lo * b_hi) << 32
        PH_HL     // + (a_hi * b_lo) << 32
    } phase_t;

    typedef struct packed {
        logic   accept;
        logic   a_load;
        a_sel_t a_sel;
        logic   mul_en;
        phase_t phase;
        k_sel_t k_sel;
        logic   hash_wr;
        logic   clear_fill;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic word_full;
        logic fill_nz;
        logic out_busy;
    } dp_sts_t;

    function automatic logic [63:0] k_value(input k_sel_t sel);
        logic [63:0] k;
        unique case (sel)
            K_P1:    k = PRIME1;
            K_P2:    k = PRIME2;
            K_F1:    k = FMIX1;
            K_F2:    k = FMIX2;
            default: k = PRIME1;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/sh64m_dp.sv
// ----------------------------------------------------------------------------
// sh64m_dp
// Datapath: byte packing, message state, shared 32x32 multiplier with
// product accumulator, and the output register.
// ----------------------------------------------------------------------------
module sh64m_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [63:0]                  in_data,
    input  logic [3:0]                   in_count,
    input  logic                         cfg_we,
    input  logic [63:0]                  cfg_wdata,
    input  sh64m_pkg::dp_cmd_t           cmd,
    output sh64m_pkg::dp_sts_t           sts,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_hash
);
    import sh64m_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] hash_reg,  hash_next;
    logic [55:0] part_reg,  part_next;
    logic [2:0]  fill_reg,  fill_next;
    logic [63:0] total_reg, total_next;
    logic        open_reg,  open_next;
    logic [63:0] a_reg;
    logic [63:0] p_reg;
    logic [63:0] out_reg;
    logic        out_valid_reg;

    logic [3:0]  n_eff;
    logic [63:0] data_m;
    logic [63:0] comb_w;
    logic [63:0] left_w;
    logic [4:0]  fill_sum;
    logic [63:0] k;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;
    logic [63:0] x_rot, x_fin, x_av;
    logic [63:0] a_next;

    // Count above eight is treated as eight; bytes above the count are dropped.
    always_comb begin
        n_eff = (in_count > 4'd8) ? 4'd8 : in_count;
        for (int i = 0; i < 8; i++) begin
            data_m[8*i +: 8] = (4'(i) < n_eff) ? in_data[8*i +: 8] : 8'h00;
        end
        comb_w   = {8'h00, part_reg} | (data_m << {fill_reg, 3'b000});
        left_w   = (fill_reg == 3'd0) ? 64'd0
                                      : (data_m >> (7'd64 - {1'b0, fill_reg, 3'b000}));
        fill_sum = {2'b00, fill_reg} + {1'b0, n_eff};
    end

    assign sts.word_full = fill_sum[3] | fill_sum[4];
    assign sts.fill_nz   = (fill_reg != 3'd0);
    assign sts.out_busy  = out_valid_reg & ~m_tready;

    // One 32x32 partial product per cycle, summed into the low 64 bits.
    always_comb begin
        k     = k_value(cmd.k_sel);
        mul_x = (cmd.phase == PH_HL) ? a_reg[63:32] : a_reg[31:0];
        mul_y = (cmd.phase == PH_LH) ? k[63:32]     : k[31:0];
        prod  = 64'(mul_x) * 64'(mul_y);
    end

    always_comb begin
        x_rot = hash_reg ^ p_reg;
        x_rot = {x_rot[63-ROT_AMOUNT:0], x_rot[63:64-ROT_AMOUNT]};
        x_fin = hash_reg ^ total_reg;
        x_fin = x_fin ^ (x_fin >> AVAL_SHIFT);
        x_av  = p_reg ^ (p_reg >> AVAL_SHIFT);
        unique case (cmd.a_sel)
            A_COMB:  a_next = comb_w;
            A_PART:  a_next = {8'h00, part_reg};
            A_ROT:   a_next = x_rot;
            A_FIN:   a_next = x_fin;
            A_AVAL:  a_next = x_av;
            default: a_next = comb_w;
        endcase
    end

    always_comb begin
        hash_next  = hash_reg;
        part_next  = part_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        open_next  = open_reg;
        if (cfg_we && !open_reg) begin
            hash_next = cfg_wdata;
        end
        if (cmd.accept && n_eff != 4'd0) begin
            open_next  = 1'b1;
            total_next = total_reg + {60'd0, n_eff};
            fill_next  = fill_sum[2:0];
            part_next  = sts.word_full ? left_w[55:0] : comb_w[55:0];
        end
        if (cmd.hash_wr) begin
            hash_next = p_reg;
        end
        if (cmd.clear_fill) begin
            fill_next = 3'd0;
        end
        // Finishing a message returns everything to the seed.
        if (cmd.out_load) begin
            hash_next  = seed_reg;
            part_next  = '0;
            fill_next  = 3'd0;
            total_next = '0;
            open_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            hash_reg      <= '0;
            part_reg      <= '0;
            fill_reg      <= 3'd0;
            total_reg     <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            hash_reg  <= hash_next;
            part_reg  <= part_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            open_reg  <= open_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.a_load) begin
            a_reg <= a_next;
        end
        if (cmd.mul_en) begin
            p_reg <= (cmd.phase == PH_LL) ? prod : (p_reg + {prod[31:0], 32'd0});
        end
        if (cmd.out_load) begin
            out_reg <= x_av;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_hash   = out_reg;

endmodule

FILE: hw/rtl/sh64m_ctrl.sv
// ----------------------------------------------------------------------------
// sh64m_ctrl
// Controller: sequences word mixing, the partial-word mix and the finalizer
// through the shared multiplier of the datapath.
// ----------------------------------------------------------------------------
module sh64m_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  sh64m_pkg::dp_sts_t  sts,
    output sh64m_pkg::dp_cmd_t  cmd
);
    import sh64m_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_reg,  last_next;
    logic   mul_done;

    assign mul_done = (phase_reg == PH_HL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LL;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = PH_LL;
        last_next      = last_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.a_sel      = A_COMB;
        cmd.phase      = phase_reg;
        cmd.k_sel      = K_P1;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    last_next  = s_tlast;
                    if (sts.word_full) begin
                        cmd.a_load = 1'b1;
                        cmd.a_sel  = A_COMB;
                        state_next = ST_W_MUL1;
                    end else if (s_tlast) begin
                        state_next = ST_F_CHK;
                    end
                end
            end
            ST_W_MUL1, ST_W_MUL2, ST_F_MUL1, ST_F_MUL2: begin
                cmd.mul_en = 1'b1;
                unique case (state_reg)
                    ST_W_MUL1: cmd.k_sel = K_P1;
                    ST_W_MUL2: cmd.k_sel = K_P2;
                    ST_F_MUL1: cmd.k_sel = K_F1;
                    default:   cmd.k_sel = K_F2;
                endcase
                unique case (phase_reg)
                    PH_LL:   phase_next = PH_LH;
                    PH_LH:   phase_next = PH_HL;
                    default: phase_next = PH_LL;
                endcase
                if (mul_done) begin
                    unique case (state_reg)
                        ST_W_MUL1: state_next = ST_W_ROT;
                        ST_W_MUL2: state_next = ST_W_DONE;
                        ST_F_MUL1: state_next = ST_F_AV;
                        default:   state_next = ST_F_OUT;
                    endcase
                end
            end
            ST_W_ROT: begin
                cmd.a_load = 1'b1;
                cmd.a_sel  = A_ROT;
                state_next = ST_W_MUL2;
            end
            ST_W_DONE: begin
                cmd.hash_wr = 1'b1;
                state_next  = last_reg ? ST_F_CHK : ST_IDLE;
            end
            ST_F_CHK: begin
                // A leftover partial word is mixed in once, zero padded.
                if (sts.fill_nz) begin
                    cmd.a_load     = 1'b1;
                    cmd.a_sel      = A_PART;
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_W_MUL1;
                end else begin
                    state_next = ST_F_LOAD;
                end
            end
            ST_F_LOAD: begin
                cmd.a_load = 1'b1;
                cmd.a_sel  = A_FIN;
                state_next = ST_F_MUL1;
            end
            ST_F_AV: begin
                cmd.a_load = 1'b1;
                cmd.a_sel  = A_AVAL;
                state_next = ST_F_MUL2;
            end
            ST_F_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    last_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/streaming_hash64_mix.sv
// ----------------------------------------------------------------------------
// streaming_hash64_mix
// Streaming 64-bit multiply-rotate hash with a shift-multiply avalanche.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries up to eight message bytes per transfer, first
// byte lowest, with the byte count beside them; s_tlast ends the message.
// Bytes are packed into 64-bit words across transfer boundaries. On the last
// transfer one master transfer carries the finished hash, after which the
// running state returns to the hash seed written through cfg_we/cfg_wdata.
// A seed written before the first byte of a message applies at once.
// All 64-bit multiplies run on one 32x32 multiplier, three partial products
// per multiply. A transfer that completes no word is taken every cycle; one
// that completes a word keeps the block busy, taking no transfer, through the
// first multiply, the rotate, the second multiply and the hash write. The last
// transfer adds the finalizer, after one more word mix if a partial word is left.
// The result waits in an output register; while it waits, new message
// transfers are still accepted, and only the next finished hash stalls until
// the master side takes the previous one. Reset (aresetn low, synchronous)
// clears the seed to zero, empties the message state and drops m_tvalid.
// ----------------------------------------------------------------------------
module streaming_hash64_mix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sh64m_pkg::S_TDATA_W-1:0]     s_tdata,   // data_bytes[63:0], byte_count[67:64]
    input  logic                                s_tlast,   // is_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sh64m_pkg::M_TDATA_W-1:0]     m_tdata,   // hash_value[63:0]
    input  logic                                cfg_we,
    input  logic [63:0]                         cfg_wdata  // hash_seed
);
    import sh64m_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    sh64m_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sh64m_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata[63:0]),
        .in_count  (s_tdata[67:64]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_hash    (m_tdata)
    );

endmodule

FILE: tb/streaming_hash64_mix_test.sv
// ----------------------------------------------------------------------------
// streaming_hash64_mix_test
// Self-checking bench for the streaming multiply-rotate hash. Byte chunks are
// sent with random gaps while the result side stalls at random. A local model
// predicts every finished hash, and each hash transfer is checked against the
// oldest pending prediction. Seed writes are made only when the block is idle.
// ----------------------------------------------------------------------------
module streaming_hash64_mix_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MUL_A   = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] MUL_B   = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] AVAL_M1 = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] AVAL_M2 = 64'hC4CE_B9FE_1A85_EC53;
    localparam int SETTLE_CYCLES   = 40;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RANDOM_CHUNKS   = 2000;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [sh64m_pkg::S_TDATA_W-1:0]     s_tdata = '0;  // data_bytes[63:0], byte_count[67:64]
    logic                                s_tlast = 1'b0; // is_last
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [sh64m_pkg::M_TDATA_W-1:0]     m_tdata;        // hash_value[63:0]
    logic                                cfg_we = 1'b0;
    logic [63:0]                         cfg_wdata = '0; // hash_seed

    streaming_hash64_mix dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Model state of the hash.
    logic [63:0] seed_reg;
    logic [63:0] hash_acc;
    logic [63:0] tail_word;
    int          tail_fill;
    logic [63:0] total_bytes;
    bit          msg_started;

    logic [63:0] pending_hashes[$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int chunks_sent = 0;
    int messages_sent = 0;
    int hashes_checked = 0;
    int seed_writes = 0;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [63:0] round_mix(logic [63:0] h, logic [63:0] w);
        logic [63:0] t;
        t = h ^ (w * MUL_A);
        t = {t[32:0], t[63:33]};
        return t * MUL_B;
    endfunction

    function automatic void start_message();
        hash_acc    = seed_reg;
        tail_word   = '0;
        tail_fill   = 0;
        total_bytes = '0;
        msg_started = 1'b0;
    endfunction

    // Applies one accepted chunk to the model; a closing chunk yields a hash.
    function automatic void absorb_chunk(logic [63:0] data, logic [3:0] nbytes, bit ends_msg);
        int          n;
        int          fill;
        logic [63:0] d;
        logic [63:0] joined;
        logic [63:0] h;
        n = (nbytes > 8) ? 8 : int'(nbytes);
        d = data;
        if (n < 8)
            d = data & ((64'd1 << (8 * n)) - 64'd1);
        if (n != 0) begin
            fill = tail_fill;
            joined = tail_word | (d << (8 * fill));
            msg_started = 1'b1;
            total_bytes += 64'(n);
            if (fill + n >= 8) begin
                hash_acc  = round_mix(hash_acc, joined);
                tail_word = (fill == 0) ? 64'd0 : (d >> (8 * (8 - fill)));
                tail_fill = fill + n - 8;
            end else begin
                tail_word = joined;
                tail_fill = fill + n;
            end
        end
        if (ends_msg) begin
            h = hash_acc;
            if (tail_fill != 0)
                h = round_mix(h, tail_word);
            h ^= total_bytes;
            h ^= h >> 33;
            h *= AVAL_M1;
            h ^= h >> 33;
            h *= AVAL_M2;
            h ^= h >> 33;
            pending_hashes.push_back(h);
            start_message();
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Sends one chunk and returns at the edge where it was accepted; s_tvalid
    // stays high so a back-to-back chunk can follow without a gap.
    task automatic send_chunk(logic [63:0] data, logic [3:0] nbytes, bit ends_msg);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, nbytes, data};
        s_tlast  <= ends_msg;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_chunk(data, nbytes, ends_msg);
        chunks_sent++;
        if (ends_msg)
            messages_sent++;
    endtask

    // Stops sending, waits for every pending hash and lets the block go idle.
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        seed_reg = value;
        if (!msg_started)
            hash_acc = value;
        seed_writes++;
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 4'd8;
        if (r < 85) return 4'($urandom_range(1, 7));
        if (r < 93) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    // Result side: random stalls, and stretches of constant readiness.
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h", m_tdata));
            end else begin
                if (m_tdata !== pending_hashes[0])
                    report_mismatch($sformatf("hash %h, expected %h",
                                              m_tdata, pending_hashes[0]));
                void'(pending_hashes.pop_front());
                hashes_checked++;
            end
        end
    end

    task automatic test_empty_messages();
        send_chunk(rand64(), 4'd0, 1'b1);
        send_chunk(64'd0, 4'd0, 1'b0);
        send_chunk('1, 4'd0, 1'b1);
    endtask

    // Single-chunk messages of every byte count, junk above the count.
    task automatic test_byte_counts();
        send_chunk('1, 4'd8, 1'b1);
        send_chunk(64'd0, 4'd8, 1'b1);
        for (int n = 0; n <= 8; n++)
            send_chunk(rand64(), 4'(n), 1'b1);
        send_chunk(rand64(), 4'd9, 1'b1);
        send_chunk('1, 4'd15, 1'b1);
    endtask

    // Chunk boundaries at byte offsets 3, 6 and 7 inside the 64-bit words, and on word edges.
    task automatic test_word_packing();
        send_chunk(rand64(), 4'd3, 1'b0);
        send_chunk(rand64(), 4'd5, 1'b0);
        send_chunk(rand64(), 4'd7, 1'b0);
        send_chunk(rand64(), 4'd1, 1'b0);
        send_chunk(rand64(), 4'd8, 1'b0);
        send_chunk(rand64(), 4'd6, 1'b1);
    endtask

    task automatic test_seed_updates();
        drain();
        write_seed('1);
        send_chunk(rand64(), 4'd8, 1'b1);
        // A seed written after bytes were taken applies from the next message.
        send_chunk(rand64(), 4'd3, 1'b0);
        drain();
        write_seed(64'h0123_4567_89AB_CDEF);
        send_chunk(rand64(), 4'd2, 1'b1);
        // Zero-byte chunks leave the message unopened, so the seed loads at once.
        send_chunk(rand64(), 4'd0, 1'b0);
        drain();
        write_seed(64'd0);
        send_chunk(rand64(), 4'd4, 1'b1);
    endtask

    task automatic test_random_messages(int target);
        int sent;
        int parts;
        int split_at;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_seed(pick_seed());
            end
            if ($urandom_range(0, 19) == 0)
                idle_on = !idle_on;
            parts = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 8);
            split_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, parts - 1) : -1;
            for (int i = 0; i < parts; i++) begin
                if (i == split_at && i != 0) begin
                    drain();
                    write_seed(pick_seed());
                end
                send_chunk(rand64(), pick_count(), i == parts - 1);
            end
            sent += parts;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        seed_reg = '0;
        start_message();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_messages();
        test_byte_counts();
        test_word_packing();
        test_seed_updates();
        test_random_messages(RANDOM_CHUNKS);

        drain();
        if (pending_hashes.size() != 0)
            report_mismatch($sformatf("%0d hashes never arrived", pending_hashes.size()));
        $display("Sent %0d chunks in %0d messages with %0d seed writes.",
                 chunks_sent, messages_sent, seed_writes);
        $display("Checked %0d hashes, %0d mismatches.", hashes_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d hashes pending.", pending_hashes.size());
        $display("FAIL");
        $finish;
    end

endmodule
